[hdl/bbe_pkg.sv]
package bbe_pkg;

    // row buffer geometry
    localparam int MAX_COLS = 64;
    localparam int COL_W    = $clog2(MAX_COLS + 1);
    localparam int ADDR_W   = $clog2(MAX_COLS);

    // field widths
    localparam int ROWS_W  = 16;
    localparam int VALUE_W = 64;
    localparam int COUNT_W = 24;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MISSING_PATTERN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODED_COUNT     = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [1:0] STATUS_SEQUENCE  = 2'd2;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        CMD_BIT,
        CMD_CODED
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t            kind;
        logic                 map_bit;
        logic [VALUE_W-1:0]   coded_value;
    } cmd_t;

    // effective configuration, already clamped
    typedef struct packed {
        logic [ROWS_W-1:0]    num_rows;
        logic [COL_W-1:0]     cols;
        logic [VALUE_W-1:0]   missing_pattern;
        logic [COUNT_W-1:0]   coded_count;
    } cfg_t;

    typedef struct packed {
        logic [VALUE_W-1:0]   value;
        logic                 missing;
        logic [1:0]           status;
        logic                 grid_done;
    } res_t;

endpackage

[hdl/bbe_ram.sv]
module bbe_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/bbe_front.sv]
module bbe_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic                         func,
    input  logic                         map_bit,
    input  logic [bbe_pkg::VALUE_W-1:0]  coded_value,
    output logic                         cmd_valid,
    output bbe_pkg::cmd_t                cmd,
    input  logic                         cmd_pop
);

    import bbe_pkg::*;

    cmd_t              queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;
    cmd_t              item_cmd;

    // classify the incoming beat
    always_comb
    begin
        item_cmd.kind        = func ? CMD_CODED : CMD_BIT;
        item_cmd.map_bit     = map_bit;
        item_cmd.coded_value = coded_value;
    end

    assign item_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push       = item_valid && !item_stall;
    assign cmd_valid  = (count_reg != '0);
    assign pop        = cmd_pop && cmd_valid;
    assign cmd        = queue_reg[rd_ptr_reg];

    // payload storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= item_cmd;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[hdl/bbe_back.sv]
module bbe_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bbe_pkg::cfg_t                cfg,
    input  logic                         cmd_valid,
    input  bbe_pkg::cmd_t                cmd,
    output logic                         cmd_pop,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic [bbe_pkg::VALUE_W-1:0]  value,
    output logic                         missing,
    output logic [1:0]                   status,
    output logic                         run_last,
    output logic                         grid_done
);

    import bbe_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_FIN
    } state_t;

    state_t              state_reg,     state_next;
    logic [COL_W-1:0]    load_col_reg,  load_col_next;
    logic [COL_W-1:0]    emit_col_reg,  emit_col_next;
    logic [ROWS_W-1:0]   row_index_reg, row_index_next;
    logic                emitting_reg,  emitting_next;
    logic [COUNT_W-1:0]  used_reg,      used_next;
    logic                pend_valid_reg, pend_valid_next;
    res_t                pend_reg,      pend_next;
    logic                out_valid_reg, out_valid_next;
    res_t                out_reg,       out_next;
    logic                out_last_reg,  out_last_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic                ram_rbit;
    logic [COL_W-1:0]    rev_col;
    logic [COL_W-1:0]    load_inc;
    logic                out_free;
    logic                can_push;
    logic                present;
    logic                last_row;
    logic                push;
    logic                finish;
    logic                restart;
    res_t                push_res;

    // row buffer, natural column order
    bbe_ram #(
        .WIDTH (1),
        .DEPTH (MAX_COLS)
    ) u_row_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.map_bit),
        .raddr (emit_col_reg[ADDR_W-1:0]),
        .rdata (ram_rbit)
    );

    assign rev_col  = cfg.cols - COL_W'(1) - load_col_reg;
    assign load_inc = (load_col_reg < cfg.cols) ? load_col_reg + COL_W'(1) : load_col_reg;
    assign out_free = !out_valid_reg || !result_stall;
    assign can_push = !pend_valid_reg || out_free;
    assign present  = ram_rbit && (cfg.coded_count != '0);
    assign last_row = ({1'b0, row_index_reg} + 17'd1) >= {1'b0, cfg.num_rows};

    // sequencer: load bits, walk the row, hold the newest result until its end is known
    always_comb
    begin
        state_next      = state_reg;
        load_col_next   = load_col_reg;
        emit_col_next   = emit_col_reg;
        row_index_next  = row_index_reg;
        emitting_next   = emitting_reg;
        used_next       = used_reg;
        cmd_pop         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = load_col_reg[ADDR_W-1:0];
        push            = 1'b0;
        finish          = 1'b0;
        restart         = 1'b0;
        push_res        = '0;
        pend_next       = pend_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (!emitting_reg)
                    begin
                        if (cmd.kind == CMD_CODED)
                        begin
                            push            = 1'b1;
                            push_res.status = STATUS_SEQUENCE;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            if (load_col_reg < cfg.cols)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = row_index_reg[0] ? rev_col[ADDR_W-1:0]
                                                             : load_col_reg[ADDR_W-1:0];
                            end
                            load_col_next = load_inc;
                            if (load_inc >= cfg.cols)
                            begin
                                emit_col_next = '0;
                                state_next    = S_READ;
                            end
                        end
                    end
                    else
                    begin
                        if (cmd.kind == CMD_BIT)
                        begin
                            push            = 1'b1;
                            push_res.status = STATUS_SEQUENCE;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            push           = 1'b1;
                            push_res.value = cmd.coded_value;
                            used_next      = used_reg + COUNT_W'(1);
                            emit_col_next  = emit_col_reg + COL_W'(1);
                            emitting_next  = 1'b0;
                            state_next     = S_READ;
                        end
                    end
                end
            end

            S_READ:
            begin
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                if (emit_col_reg >= cfg.cols)
                begin
                    // row complete
                    if (last_row)
                    begin
                        pend_next.grid_done = 1'b1;
                        restart             = 1'b1;
                    end
                    else
                    begin
                        row_index_next = row_index_reg + ROWS_W'(1);
                        load_col_next  = '0;
                        emit_col_next  = '0;
                        emitting_next  = 1'b0;
                    end
                    state_next = S_FIN;
                end
                else if (present)
                begin
                    if (used_reg >= cfg.coded_count)
                    begin
                        // coded values exhausted, grid ends
                        if (can_push)
                        begin
                            push               = 1'b1;
                            push_res.status    = STATUS_EXHAUSTED;
                            push_res.grid_done = 1'b1;
                            restart            = 1'b1;
                            state_next         = S_FIN;
                        end
                    end
                    else
                    begin
                        emitting_next = 1'b1;
                        state_next    = pend_valid_reg ? S_FIN : S_IDLE;
                    end
                end
                else if (can_push)
                begin
                    push             = 1'b1;
                    push_res.value   = cfg.missing_pattern;
                    push_res.missing = 1'b1;
                    emit_col_next    = emit_col_reg + COL_W'(1);
                    state_next       = S_READ;
                end
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (restart)
        begin
            row_index_next = '0;
            used_next      = '0;
            load_col_next  = '0;
            emit_col_next  = '0;
            emitting_next  = 1'b0;
        end
    end

    // pending result and output register
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && result_stall;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        if (push)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
        end
        if (finish)
        begin
            out_valid_next  = 1'b1;
            out_next        = pend_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            load_col_reg   <= '0;
            emit_col_reg   <= '0;
            row_index_reg  <= '0;
            emitting_reg   <= 1'b0;
            used_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_col_reg   <= load_col_next;
            emit_col_reg   <= emit_col_next;
            row_index_reg  <= row_index_next;
            emitting_reg   <= emitting_next;
            used_reg       <= used_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            out_last_reg   <= out_last_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            pend_reg <= push_res;
        end
        else
        begin
            pend_reg <= pend_next;
        end
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign value        = out_reg.value;
    assign missing      = out_reg.missing;
    assign status       = out_reg.status;
    assign run_last     = out_last_reg;
    assign grid_done    = out_reg.grid_done;

    // checks
    a_fin_has_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> pend_valid_reg)
        else $error("final state without a pending result");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("pending result left over between items");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.grid_done) |-> out_last_reg)
        else $error("grid end not on the last result of its item");

    a_cols_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (load_col_reg <= COL_W'(MAX_COLS)) && (emit_col_reg <= COL_W'(MAX_COLS)))
        else $error("column counter beyond row buffer");

    a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (emitting_reg && state_reg == S_IDLE) |-> (emit_col_reg < cfg.cols))
        else $error("awaiting a coded value past the row end");

endmodule

[hdl/boustrophedonic_bitmap_expand_unit.sv]
// Boustrophedonic bitmap expansion unit.
// Item channel (item_valid/item_stall): func 0 carries one presence bit in
// stored order, func 1 carries one coded value. A beat is taken when
// item_valid is high and item_stall low; a two-entry command queue parts
// the input from the row sequencer, so input is taken while results wait.
// Result channel (result_valid/result_stall): one grid point per beat, in
// natural order; run_last marks the last result of an item, grid_done the
// final point of the grid or an exhausted result.
// A presence bit that leaves its row open is only stored; each walked point
// takes a row buffer RAM read, then evaluation; an item leaves the queue, then closes.
// Configuration (cfg_we/cfg_index/cfg_data) is written while the unit is idle.
// Reset clears the grid position and queue, and loads the register reset
// values; the row buffer needs no clearing pass.
// With result_stall high the output beat holds; the walk pauses and the
// queue fills, then item_stall rises.
module boustrophedonic_bitmap_expand_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bbe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bbe_pkg::CFG_W-1:0]      cfg_data,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic                           func,
    input  logic                           map_bit,
    input  logic [bbe_pkg::VALUE_W-1:0]    coded_value,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [bbe_pkg::VALUE_W-1:0]    value,
    output logic                           missing,
    output logic [1:0]                     status,
    output logic                           run_last,
    output logic                           grid_done
);

    import bbe_pkg::*;

    logic [ROWS_W-1:0]  num_rows_reg;
    logic [COL_W-1:0]   num_cols_reg;
    logic [VALUE_W-1:0] missing_pattern_reg;
    logic [COUNT_W-1:0] coded_count_reg;
    cfg_t               cfg;
    logic               cmd_valid;
    cmd_t               cmd;
    logic               cmd_pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg        <= ROWS_W'(1);
            num_cols_reg        <= COL_W'(MAX_COLS);
            missing_pattern_reg <= '0;
            coded_count_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NUM_ROWS:        num_rows_reg        <= cfg_data[ROWS_W-1:0];
                CFG_NUM_COLS:        num_cols_reg        <= cfg_data[COL_W-1:0];
                CFG_MISSING_PATTERN: missing_pattern_reg <= cfg_data[VALUE_W-1:0];
                CFG_CODED_COUNT:     coded_count_reg     <= cfg_data[COUNT_W-1:0];
                default:             num_rows_reg        <= num_rows_reg;
            endcase
        end
    end

    // clamp rows and columns to their usable range
    always_comb
    begin
        cfg.num_rows        = (num_rows_reg == '0) ? ROWS_W'(1) : num_rows_reg;
        if (num_cols_reg == '0)
        begin
            cfg.cols = COL_W'(1);
        end
        else if (num_cols_reg > COL_W'(MAX_COLS))
        begin
            cfg.cols = COL_W'(MAX_COLS);
        end
        else
        begin
            cfg.cols = num_cols_reg;
        end
        cfg.missing_pattern = missing_pattern_reg;
        cfg.coded_count     = coded_count_reg;
    end

    bbe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .func        (func),
        .map_bit     (map_bit),
        .coded_value (coded_value),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    bbe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_pop      (cmd_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .value        (value),
        .missing      (missing),
        .status       (status),
        .run_last     (run_last),
        .grid_done    (grid_done)
    );

endmodule
